// ----- rtl/ckh_pkg.sv -----
package ckh_pkg;

	// Channel and register widths
	localparam int PIX_W      = 8;
	localparam int HUE_W      = 8;
	localparam int SAT_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BG_BLUE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BG_RED   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUE_TOL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_TOL  = 3'd4;

	// Register values after reset
	localparam logic [CFG_DATA_W-1:0] RST_BG_BLUE  = 8'd0;
	localparam logic [CFG_DATA_W-1:0] RST_BG_GREEN = 8'd255;
	localparam logic [CFG_DATA_W-1:0] RST_BG_RED   = 8'd0;
	localparam logic [CFG_DATA_W-1:0] RST_HUE_TOL  = 8'd14;
	localparam logic [CFG_DATA_W-1:0] RST_SAT_TOL  = 8'd120;

	// Pipeline depth: conversion lane, then one compare stage
	localparam int LANE_STAGES = 7;
	localparam int STAGES      = LANE_STAGES + 1;

	// Reciprocal dividers: 21 quotient bits, one extra step in the first stage
	localparam int DIV_W     = 21;
	localparam int DEN_W     = PIX_W + 1;
	localparam int DIV_STEPS = 5;

	// Doubled numerators of round(255*4096/v) and round(30*4096/diff)
	localparam logic [DIV_W-1:0] SAT_NUM = 21'd2088960;
	localparam logic [DIV_W-1:0] HUE_NUM = 21'd245760;

	// Q12 rounding and hue wrap
	localparam int FRAC_W = 12;
	localparam int HALF_Q12 = 2048;
	localparam logic signed [HUE_W:0] HUE_WRAP = 9'sd180;

	// Signed width of the raw sector hue numerator
	localparam int HNUM_W = 12;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem;
		logic [DIV_W-1:0] nq;
	} div_t;

	typedef struct packed {
		div_t                     sd;
		div_t                     hd;
		logic [PIX_W-1:0]         diff;
		logic signed [HNUM_W-1:0] hnum;
	} lane_t;

	// One restoring division step: shift a numerator bit in, a quotient bit out
	function automatic div_t div_step(input div_t d);
		div_t           r;
		logic [DEN_W:0] trial;
		logic           ge;
		r     = d;
		trial = {d.rem, d.nq[DIV_W-1]};
		ge    = (trial >= {1'b0, d.den});
		r.rem = ge ? DEN_W'(trial - {1'b0, d.den}) : trial[DEN_W-1:0];
		r.nq  = {d.nq[DIV_W-2:0], ge};
		return r;
	endfunction

	// A fixed run of division steps for one stage
	function automatic div_t div_run(input div_t d);
		div_t r;
		r = d;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r = div_step(r);
		end
		return r;
	endfunction

endpackage

// ----- rtl/ckh_ifs.sv -----
interface ckh_pix_if;
	logic                       valid;
	logic                       ready;
	logic [ckh_pkg::PIX_W-1:0]  pix_blue;
	logic [ckh_pkg::PIX_W-1:0]  pix_green;
	logic [ckh_pkg::PIX_W-1:0]  pix_red;

	modport source (output valid, output pix_blue, output pix_green, output pix_red,
		input ready);
	modport sink (input valid, input pix_blue, input pix_green, input pix_red,
		output ready);
endinterface

interface ckh_mask_if;
	logic valid;
	logic ready;
	logic is_foreground;

	modport source (output valid, output is_foreground, input ready);
	modport sink (input valid, input is_foreground, output ready);
endinterface

// ----- rtl/ckh_hs_pipe.sv -----
module ckh_hs_pipe (
	input  logic                           clk,
	input  logic [ckh_pkg::LANE_STAGES:1]  en,
	input  logic [ckh_pkg::PIX_W-1:0]      blue,
	input  logic [ckh_pkg::PIX_W-1:0]      green,
	input  logic [ckh_pkg::PIX_W-1:0]      red,
	output logic [ckh_pkg::HUE_W-1:0]      hue,
	output logic [ckh_pkg::SAT_W-1:0]      sat
);
	import ckh_pkg::*;

	localparam int SPROD_W = PIX_W + DIV_W;
	localparam int HPROD_W = HNUM_W + DIV_W + 1;

	logic [PIX_W-1:0]         vmax;
	logic [PIX_W-1:0]         vmin;
	logic [PIX_W-1:0]         diff;
	logic signed [HNUM_W-1:0] hnum;
	lane_t                    st_d;

	lane_t st_s1, st_s2, st_s3, st_s4, st_s5;

	logic [SPROD_W-1:0]         sprod_s6;
	logic signed [HPROD_W-1:0]  hprod_s6;

	logic [SPROD_W-1:0]         ssum;
	logic signed [HPROD_W-1:0]  hsum;
	logic signed [HUE_W:0]      hq;

	logic [HUE_W-1:0] hue_s7;
	logic [SAT_W-1:0] sat_s7;

	// Find max, min and the sector numerator; red wins ties, then green
	always_comb begin
		vmax = blue;
		vmin = blue;
		if (green > vmax) vmax = green;
		if (red > vmax)   vmax = red;
		if (green < vmin) vmin = green;
		if (red < vmin)   vmin = red;
		diff = vmax - vmin;
		if (vmax == red) begin
			hnum = $signed(HNUM_W'(green)) - $signed(HNUM_W'(blue));
		end else if (vmax == green) begin
			hnum = $signed(HNUM_W'(blue)) - $signed(HNUM_W'(red))
				+ $signed(HNUM_W'({diff, 1'b0}));
		end else begin
			hnum = $signed(HNUM_W'(red)) - $signed(HNUM_W'(green))
				+ $signed(HNUM_W'({diff, 2'b00}));
		end
		st_d.sd.den = {vmax, 1'b0};
		st_d.sd.rem = '0;
		st_d.sd.nq  = SAT_NUM + DIV_W'(vmax);
		st_d.hd.den = {diff, 1'b0};
		st_d.hd.rem = '0;
		st_d.hd.nq  = HUE_NUM + DIV_W'(diff);
		st_d.diff   = diff;
		st_d.hnum   = hnum;
	end

	// Stage 1: load the dividers
	always_ff @(posedge clk) begin
		if (en[1]) st_s1 <= st_d;
	end

	// Stages 2 to 5: advance both reciprocal dividers
	always_ff @(posedge clk) begin
		if (en[2]) begin
			st_s2 <= '{sd: div_run(div_step(st_s1.sd)), hd: div_run(div_step(st_s1.hd)),
				diff: st_s1.diff, hnum: st_s1.hnum};
		end
		if (en[3]) begin
			st_s3 <= '{sd: div_run(st_s2.sd), hd: div_run(st_s2.hd),
				diff: st_s2.diff, hnum: st_s2.hnum};
		end
		if (en[4]) begin
			st_s4 <= '{sd: div_run(st_s3.sd), hd: div_run(st_s3.hd),
				diff: st_s3.diff, hnum: st_s3.hnum};
		end
		if (en[5]) begin
			st_s5 <= '{sd: div_run(st_s4.sd), hd: div_run(st_s4.hd),
				diff: st_s4.diff, hnum: st_s4.hnum};
		end
	end

	// Stage 6: scale by the reciprocals
	always_ff @(posedge clk) begin
		if (en[6]) begin
			sprod_s6 <= SPROD_W'(st_s5.diff) * SPROD_W'(st_s5.sd.nq);
			hprod_s6 <= HPROD_W'(st_s5.hnum) * $signed(HPROD_W'({1'b0, st_s5.hd.nq}));
		end
	end

	// Round half up out of Q12; negative hues are wrapped in stage 7
	always_comb begin
		ssum = sprod_s6 + SPROD_W'(HALF_Q12);
		hsum = hprod_s6 + HPROD_W'(HALF_Q12);
		hq   = hsum[FRAC_W+HUE_W:FRAC_W];
	end

	// Stage 7: hold hue and saturation
	always_ff @(posedge clk) begin
		if (en[7]) begin
			sat_s7 <= ssum[FRAC_W+SAT_W-1:FRAC_W];
			hue_s7 <= hq[HUE_W] ? HUE_W'(hq + HUE_WRAP) : hq[HUE_W-1:0];
		end
	end

	assign hue = hue_s7;
	assign sat = sat_s7;

endmodule

// ----- rtl/chroma_key_hsv_classifier.sv -----
// Chroma-key classifier: marks each pixel as foreground or background against
// a key colour, comparing hue and saturation in 8-bit HSV.
//
// Channels: pix takes one blue/green/red word per accepted handshake; mask
// returns one is_foreground word per pixel, in order. Configuration is a plain
// write port (cfg_we, cfg_idx, cfg_wdata): 0 bg_blue, 1 bg_green, 2 bg_red,
// 3 hue_tolerance, 4 sat_tolerance; other indexes are dropped. Write only
// while no pixel is in flight.
//
// Throughput: one pixel per cycle while mask is ready. The depth is set by a
// load stage, two 21-bit restoring reciprocal dividers per lane run over four
// stages (five or six steps each), a multiply, a rounding stage and the
// compare stage.
//
// Reset clears all valid bits and loads the key colour to pure green with
// hue tolerance 14 and saturation tolerance 120. When mask is stalled, each
// stage keeps its word and empty stages still fill, so pix stays ready until
// all eight stages hold words.
module chroma_key_hsv_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	ckh_pix_if.sink                       pix,
	ckh_mask_if.source                    mask,
	input  logic                          cfg_we,
	input  logic [ckh_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ckh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ckh_pkg::*;

	logic [CFG_DATA_W-1:0] bg_blue_q, bg_green_q, bg_red_q, hue_tol_q, sat_tol_q;

	logic [STAGES:1] vld_q;
	logic [STAGES:1] en;

	logic [HUE_W-1:0] pix_hue, bg_hue;
	logic [SAT_W-1:0] pix_sat, bg_sat;

	logic signed [HUE_W:0] dh;
	logic signed [SAT_W:0] ds;
	logic [HUE_W:0]        dh_abs;
	logic [SAT_W:0]        ds_abs;

	logic fg_s8;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_blue_q  <= RST_BG_BLUE;
			bg_green_q <= RST_BG_GREEN;
			bg_red_q   <= RST_BG_RED;
			hue_tol_q  <= RST_HUE_TOL;
			sat_tol_q  <= RST_SAT_TOL;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BG_BLUE:  bg_blue_q  <= cfg_wdata;
				REG_BG_GREEN: bg_green_q <= cfg_wdata;
				REG_BG_RED:   bg_red_q   <= cfg_wdata;
				REG_HUE_TOL:  hue_tol_q  <= cfg_wdata;
				REG_SAT_TOL:  sat_tol_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en[STAGES] = ~vld_q[STAGES] | mask.ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	// Move valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= pix.valid;
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign pix.ready = en[1];

	// Convert the pixel and the key colour side by side
	ckh_hs_pipe u_pix_hs (
		.clk   (clk),
		.en    (en[LANE_STAGES:1]),
		.blue  (pix.pix_blue),
		.green (pix.pix_green),
		.red   (pix.pix_red),
		.hue   (pix_hue),
		.sat   (pix_sat)
	);

	ckh_hs_pipe u_bg_hs (
		.clk   (clk),
		.en    (en[LANE_STAGES:1]),
		.blue  (bg_blue_q),
		.green (bg_green_q),
		.red   (bg_red_q),
		.hue   (bg_hue),
		.sat   (bg_sat)
	);

	// Absolute differences, no hue wrap
	always_comb begin
		dh     = $signed({1'b0, bg_hue}) - $signed({1'b0, pix_hue});
		ds     = $signed({1'b0, bg_sat}) - $signed({1'b0, pix_sat});
		dh_abs = dh[HUE_W] ? (HUE_W+1)'(-dh) : dh;
		ds_abs = ds[SAT_W] ? (SAT_W+1)'(-ds) : ds;
	end

	// Stage 8: compare against the tolerances
	always_ff @(posedge clk) begin
		if (en[STAGES]) begin
			fg_s8 <= (dh_abs > {1'b0, hue_tol_q}) || (ds_abs > {1'b0, sat_tol_q});
		end
	end

	assign mask.valid         = vld_q[STAGES];
	assign mask.is_foreground = fg_s8;

endmodule
